@@ hdl/tracker_sample_data_decoder_assert.svh @@
`ifndef TRACKER_SAMPLE_DATA_DECODER_ASSERT_SVH
`define TRACKER_SAMPLE_DATA_DECODER_ASSERT_SVH

// same-cycle implication
`define TSDD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSDD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/tsdd_pkg.sv @@
package tsdd_pkg;

  localparam int TAG_LENGTH      = 5;
  localparam int TABLE_ENTRIES   = 16;
  localparam int COUNT_W         = 17;
  localparam int DATA_W          = 8;
  localparam int SAMPLE_W        = 16;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int TAG_BUF_AW      = $clog2(TAG_LENGTH - 1);
  localparam int NUM_W           = $clog2(TAG_LENGTH + 1);
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;

  localparam logic [DATA_W-1:0] TAG_CHARS [TAG_LENGTH] = '{8'h41, 8'h44, 8'h50, 8'h43, 8'h4D};

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [TAG_LENGTH*DATA_W-1:0] data;
    logic [NUM_W-1:0]             num;
    logic                         body_end;
    logic                         compressed;
  } cmd_t;

  function automatic data_t to_upper(input data_t c);
    return (c >= 8'h61 && c <= 8'h7A) ? data_t'(c - 8'h20) : c;
  endfunction

endpackage

@@ hdl/tsdd_front.sv @@
module tsdd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [tsdd_pkg::COUNT_W-1:0] sample_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tsdd_pkg::data_t           data_byte,
  output logic                      q_push,
  output tsdd_pkg::cmd_t            q_entry,
  input  logic                      q_full
);
  import tsdd_pkg::*;

  typedef enum logic [4:0] {
    PH_TAG    = 5'b00001,
    PH_TABLE  = 5'b00010,
    PH_DECODE = 5'b00100,
    PH_PCM    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [COUNT_W-1:0] done, done_next;
  data_t              tag_buf [TAG_LENGTH-1];
  data_t              delta_mem [TABLE_ENTRIES];
  data_t              rd_lo, rd_hi;
  logic               cmd_valid;
  cmd_t               cmd, new_cmd;
  logic               emit, tag_we, table_we, accept;
  logic [COUNT_W-1:0] done_p1, done_p2;
  logic               last_one, tag_match;

  assign in_ready = !cmd_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = cmd_valid && !q_full;
  assign done_p1  = done + COUNT_W'(1);
  assign done_p2  = done + COUNT_W'(2);
  assign last_one = (done_p1 == sample_count);

  always_comb begin
    tag_match = (to_upper(data_byte) == TAG_CHARS[TAG_LENGTH-1]);
    for (int i = 0; i < TAG_LENGTH - 1; i++) begin
      if (to_upper(tag_buf[i]) != TAG_CHARS[i]) begin
        tag_match = 1'b0;
      end
    end
  end

  always_comb begin
    emit       = 1'b0;
    tag_we     = 1'b0;
    table_we   = 1'b0;
    new_cmd    = '0;
    phase_next = phase;
    idx_next   = idx;
    done_next  = done;
    unique case (phase)
      PH_TAG: begin
        if (sample_count == '0) begin
          emit = 1'b0;
        end else if (sample_count < COUNT_W'(TAG_LENGTH)) begin
          emit                   = 1'b1;
          new_cmd.data[DATA_W-1:0] = data_byte;
          new_cmd.num            = NUM_W'(1);
          new_cmd.body_end       = last_one;
          done_next              = done_p1;
          phase_next             = last_one ? PH_DONE : PH_PCM;
        end else begin
          tag_we = 1'b1;
          if (idx == IDX_W'(TAG_LENGTH - 1)) begin
            idx_next = '0;
            if (tag_match) begin
              phase_next = PH_TABLE;
            end else begin
              emit = 1'b1;
              for (int i = 0; i < TAG_LENGTH - 1; i++) begin
                new_cmd.data[i*DATA_W +: DATA_W] = tag_buf[i];
              end
              new_cmd.data[(TAG_LENGTH-1)*DATA_W +: DATA_W] = data_byte;
              new_cmd.num      = NUM_W'(TAG_LENGTH);
              new_cmd.body_end = (sample_count == COUNT_W'(TAG_LENGTH));
              done_next        = COUNT_W'(TAG_LENGTH);
              phase_next       = new_cmd.body_end ? PH_DONE : PH_PCM;
            end
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      PH_TABLE: begin
        table_we = 1'b1;
        if (idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          idx_next   = '0;
          phase_next = PH_DECODE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      PH_PCM: begin
        emit                     = 1'b1;
        new_cmd.data[DATA_W-1:0] = data_byte;
        new_cmd.num              = NUM_W'(1);
        new_cmd.body_end         = last_one;
        done_next                = done_p1;
        phase_next               = last_one ? PH_DONE : PH_PCM;
      end
      PH_DECODE: begin
        emit               = 1'b1;
        new_cmd.compressed = 1'b1;
        if (last_one) begin
          new_cmd.num      = NUM_W'(1);
          new_cmd.body_end = 1'b1;
          done_next        = done_p1;
          phase_next       = PH_DONE;
        end else begin
          new_cmd.num      = NUM_W'(2);
          new_cmd.body_end = (done_p2 == sample_count);
          done_next        = done_p2;
          phase_next       = new_cmd.body_end ? PH_DONE : PH_DECODE;
        end
      end
      PH_DONE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase     <= PH_TAG;
      idx       <= '0;
      done      <= '0;
      cmd_valid <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      idx       <= idx_next;
      done      <= done_next;
      cmd_valid <= emit;
    end else if (q_push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= new_cmd;
      if (tag_we && idx < IDX_W'(TAG_LENGTH - 1)) begin
        tag_buf[idx[TAG_BUF_AW-1:0]] <= data_byte;
      end
    end
  end

  // delta table, two read ports
  always_ff @(posedge clk) begin
    if (accept && table_we) begin
      delta_mem[idx] <= data_byte;
    end
    if (accept) begin
      rd_lo <= delta_mem[data_byte[3:0]];
      rd_hi <= delta_mem[data_byte[7:4]];
    end
  end

  always_comb begin
    q_entry = cmd;
    if (cmd.compressed) begin
      q_entry.data                = '0;
      q_entry.data[2*DATA_W-1:0] = {rd_hi, rd_lo};
    end
  end

endmodule

@@ hdl/tsdd_queue.sv @@
module tsdd_queue #(
  parameter int DEPTH = tsdd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsdd_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output tsdd_pkg::cmd_t dout,
  output logic           not_empty
);
  import tsdd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ hdl/tsdd_back.sv @@
module tsdd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic                                q_valid,
  input  tsdd_pkg::cmd_t                      q_head,
  output logic                                q_pop,
  output logic signed [tsdd_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                run_last,
  output logic                                body_end,
  output logic                                was_compressed,
  output logic                                out_valid,
  input  logic                                out_ready
);
  import tsdd_pkg::*;

  logic [NUM_W-1:0] slot;
  data_t            rv, cur, sum, value;
  logic             load, last;

  assign cur   = q_head.data[{slot, 3'b000} +: DATA_W];
  assign sum   = rv + cur;
  assign value = q_head.compressed ? sum : cur;
  assign last  = (slot == q_head.num - NUM_W'(1));
  assign load  = q_valid && (!out_valid || out_ready);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
      rv        <= '0;
    end else if (restart) begin
      slot <= '0;
      rv   <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      slot      <= last ? '0 : slot + NUM_W'(1);
      if (q_head.compressed) begin
        rv <= sum;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_value   <= {value, 8'h00};
      run_last       <= last;
      body_end       <= q_head.body_end && last;
      was_compressed <= q_head.compressed;
    end
  end

endmodule

@@ hdl/tracker_sample_data_decoder.sv @@
// path: byte -> command register -> queue -> output register
// throughput: one sample per cycle unless stalled by out_ready or the queue;
//   compressed byte: up to two samples; plain byte: one; replayed tag: five
// tag and table bytes give no samples unless an unmatched tag is replayed
// reset: synchronous rst clears phase, counters, running value and queue;
//   the delta table and tag buffer are not cleared
module tracker_sample_data_decoder #(
  parameter int QUEUE_DEPTH = tsdd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsdd_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [tsdd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [tsdd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  input  logic [tsdd_pkg::DATA_W-1:0]           data_byte,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic signed [tsdd_pkg::SAMPLE_W-1:0]  sample_value,
  output logic                                  run_last,
  output logic                                  body_end,
  output logic                                  was_compressed,
  output logic                                  out_valid,
  input  logic                                  out_ready
);
  import tsdd_pkg::*;

  logic [COUNT_W-1:0] sample_count;
  logic               restart, q_push, q_full, q_pop, q_valid, reg_hit;
  cmd_t               q_entry, q_head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_SAMPLE_COUNT);
  assign restart = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(sample_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (restart) begin
      sample_count <= pwdata[COUNT_W-1:0];
    end
  end

  tsdd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .sample_count (sample_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .q_push       (q_push),
    .q_entry      (q_entry),
    .q_full       (q_full)
  );

  tsdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_head),
    .not_empty (q_valid)
  );

  tsdd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .restart        (restart),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .sample_value   (sample_value),
    .run_last       (run_last),
    .body_end       (body_end),
    .was_compressed (was_compressed),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

@@ hdl/tsdd_checker.sv @@
`include "tracker_sample_data_decoder_assert.svh"

module tsdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        run_last,
  input logic        body_end,
  input logic [15:0] sample_value
);

  `TSDD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_value) && $stable(body_end), "result changed while stalled")
  `TSDD_ASSERT_IMP(a_end_is_last, clk, rst, out_valid && body_end, run_last, "body end not on last sample of its byte")
  `TSDD_ASSERT_NXT(a_nothing_after_end, clk, rst, out_valid && out_ready && body_end, !out_valid, "result after end of body")
  `TSDD_ASSERT_IMP(a_low_byte_zero, clk, rst, out_valid, sample_value[7:0] == 8'h00, "sample low byte not zero")

endmodule

bind tracker_sample_data_decoder tsdd_checker u_checker (.*);
